// ===== hw/rtl/sdi_pkg.sv =====
// Package for the SD card bring-up sequencer: event, status and response codes,
// the transaction and result records, the command table and the CSD capacity decode.
// Has no dependencies; every other file of the sequencer imports it.
package sdi_pkg;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_CMD_DONE = 2'd1;
  localparam logic [1:0] ACT_DATA_DONE = 2'd2;
  localparam logic [1:0] ACT_TICK = 2'd3;

  localparam logic [2:0] STAT_IDLE = 3'd0;
  localparam logic [2:0] STAT_BUSY = 3'd1;
  localparam logic [2:0] STAT_READY = 3'd2;
  localparam logic [2:0] STAT_NO_STATUS = 3'd3;
  localparam logic [2:0] STAT_FAILED = 3'd4;

  localparam logic [1:0] RESP_NONE = 2'd0;
  localparam logic [1:0] RESP_SHORT = 2'd1;
  localparam logic [1:0] RESP_LONG = 2'd3;

  localparam logic [1:0] CSD_V1 = 2'd0;
  localparam logic [1:0] CSD_V2 = 2'd1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
  localparam logic [31:0] OP_COND_ARG = 32'hC010_0000;
  localparam logic [31:0] BUS_WIDTH_ARG = 32'h0000_0002;
  localparam logic [7:0] SPEED_RAW_TEN = 8'd8;
  localparam logic [7:0] SPEED_TEN = 8'd10;

  typedef struct packed {
    logic [1:0]  action;
    logic        resp_ok;
    logic        resp_timed_out;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic        data_ok;
    logic [7:0]  status_byte_eight;
    logic [7:0]  status_byte_fourteen;
  } item_t;

  typedef struct packed {
    logic        issue_command;
    logic [5:0]  command_index;
    logic [31:0] command_argument;
    logic [1:0]  response_kind;
    logic        expect_data_read;
    logic [2:0]  init_status;
    logic [15:0] card_address;
    logic [1:0]  csd_structure;
    logic [31:0] capacity_kib;
    logic [7:0]  speed_class;
    logic [3:0]  uhs_class;
  } result_t;

  typedef struct packed {
    logic [5:0]  index;
    logic [31:0] arg;
    logic        use_rca;
    logic [1:0]  resp;
    logic        data;
  } cmd_t;

  function automatic cmd_t cmd_entry(input logic [3:0] idx);
    cmd_t c;
    c = '{index: 6'd0, arg: 32'd0, use_rca: 1'b0, resp: RESP_NONE, data: 1'b0};
    case (idx)
      4'd2: c = '{6'd8, IF_COND_ARG, 1'b0, RESP_SHORT, 1'b0};
      4'd3: c = '{6'd55, 32'd0, 1'b0, RESP_SHORT, 1'b0};
      4'd4: c = '{6'd41, OP_COND_ARG, 1'b0, RESP_SHORT, 1'b0};
      4'd5: c = '{6'd2, 32'd0, 1'b0, RESP_LONG, 1'b0};
      4'd6: c = '{6'd3, 32'd0, 1'b0, RESP_SHORT, 1'b0};
      4'd7: c = '{6'd9, 32'd0, 1'b1, RESP_LONG, 1'b0};
      4'd8: c = '{6'd13, 32'd0, 1'b1, RESP_SHORT, 1'b0};
      4'd9: c = '{6'd7, 32'd0, 1'b1, RESP_SHORT, 1'b0};
      4'd10: c = '{6'd13, 32'd0, 1'b1, RESP_SHORT, 1'b0};
      4'd11: c = '{6'd55, 32'd0, 1'b1, RESP_SHORT, 1'b0};
      4'd12: c = '{6'd6, BUS_WIDTH_ARG, 1'b0, RESP_SHORT, 1'b0};
      4'd13: c = '{6'd13, 32'd0, 1'b1, RESP_SHORT, 1'b0};
      4'd14: c = '{6'd55, 32'd0, 1'b1, RESP_SHORT, 1'b0};
      4'd15: c = '{6'd13, 32'd0, 1'b0, RESP_SHORT, 1'b1};
      default: c = '{6'd0, 32'd0, 1'b0, RESP_NONE, 1'b0};
    endcase
    return c;
  endfunction

  function automatic logic [31:0] csd_capacity(input logic [31:0] w1, input logic [31:0] w2,
                                               input logic [31:0] w3);
    logic [11:0] c_size_v1;
    logic [4:0]  shift;
    logic [47:0] bytes;
    logic [21:0] c_size_v2;
    logic [22:0] blocks_v2;
    logic [31:0] cap;
    c_size_v1 = {w2[9:0], w3[31:30]};
    shift = 5'(w3[17:15]) + 5'd2 + 5'(w2[19:16]);
    bytes = (48'(c_size_v1) + 48'd1) << shift;
    c_size_v2 = {w2[5:0], w3[31:16]};
    blocks_v2 = 23'(c_size_v2) + 23'd1;
    case (w1[31:30])
      CSD_V1: cap = bytes[41:10];
      CSD_V2: cap = {blocks_v2, 9'd0};
      default: cap = 32'd0;
    endcase
    return cap;
  endfunction

endpackage

// ===== hw/rtl/sdi_core.sv =====
// Sequencer core: holds the bring-up step, tick counter and captured card values,
// and computes the result of one transaction combinationally.
// Depends on sdi_pkg.
module sdi_core
  import sdi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] timeout_ticks,
  input  logic        go,
  input  item_t       item,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'd0, ST_CMD0, ST_CMD8, ST_POLL55, ST_ACMD41, ST_CMD2, ST_CMD3,
    ST_CMD9, ST_STAT1, ST_SEL, ST_STAT2, ST_APP1, ST_BUSW, ST_STAT3,
    ST_APP2, ST_SDSTAT, ST_DATA, ST_END
  } step_t;

  step_t       step, step_next, target;
  logic [15:0] ticks, ticks_next;
  logic [15:0] rca, rca_next;
  logic [1:0]  csd, csd_next;
  logic [31:0] cap, cap_next;
  logic [7:0]  speed, speed_next;
  logic [3:0]  uhs, uhs_next;
  logic [2:0]  status, status_next, fin_code;
  logic        emit_cmd, emit_fin;
  logic [7:0]  speed_raw;
  cmd_t        cmd;

  always_comb begin
    step_next = step;
    ticks_next = ticks;
    rca_next = rca;
    csd_next = csd;
    cap_next = cap;
    speed_next = speed;
    uhs_next = uhs;
    status_next = status;
    emit_cmd = 1'b0;
    emit_fin = 1'b0;
    target = step;
    fin_code = STAT_FAILED;
    speed_raw = {item.status_byte_eight[6:0], 1'b0};
    unique case (item.action)
      ACT_START: begin
        ticks_next = 16'd0;
        rca_next = 16'd0;
        csd_next = 2'd0;
        cap_next = 32'd0;
        speed_next = 8'd0;
        uhs_next = 4'd0;
        emit_cmd = 1'b1;
        target = ST_CMD0;
      end
      ACT_TICK: begin
        if ((step == ST_POLL55 || step == ST_ACMD41) && ticks != 16'hFFFF) begin
          ticks_next = ticks + 16'd1;
        end
      end
      ACT_DATA_DONE: begin
        if (step == ST_DATA) begin
          emit_fin = 1'b1;
          if (!item.data_ok) begin
            fin_code = STAT_NO_STATUS;
          end else begin
            speed_next = (speed_raw == SPEED_RAW_TEN) ? SPEED_TEN : speed_raw;
            uhs_next = item.status_byte_fourteen[7:4];
            fin_code = STAT_READY;
          end
        end
      end
      default: begin
        unique case (step) inside
          ST_CMD0: begin
            emit_cmd = 1'b1;
            target = ST_CMD8;
          end
          ST_CMD8: begin
            if (item.resp_ok || item.resp_timed_out) begin
              ticks_next = 16'd0;
              emit_cmd = 1'b1;
              target = ST_POLL55;
            end else begin
              emit_fin = 1'b1;
            end
          end
          ST_POLL55: begin
            if (item.resp_ok) begin
              emit_cmd = 1'b1;
              target = ST_ACMD41;
            end else begin
              emit_fin = 1'b1;
            end
          end
          ST_ACMD41: begin
            if (ticks >= timeout_ticks) begin
              emit_fin = 1'b1;
            end else begin
              emit_cmd = 1'b1;
              target = item.resp_word1[31] ? ST_CMD2 : ST_POLL55;
            end
          end
          ST_SDSTAT: begin
            if (!item.resp_ok) begin
              emit_fin = 1'b1;
              fin_code = STAT_NO_STATUS;
            end else begin
              step_next = ST_DATA;
            end
          end
          ST_CMD2, ST_CMD3, ST_CMD9, ST_STAT1, ST_SEL, ST_STAT2, ST_APP1, ST_BUSW,
          ST_STAT3, ST_APP2: begin
            if (!item.resp_ok) begin
              emit_fin = 1'b1;
            end else begin
              if (step == ST_CMD3) begin
                rca_next = item.resp_word1[31:16];
              end
              if (step == ST_CMD9) begin
                csd_next = item.resp_word1[31:30];
                cap_next = csd_capacity(item.resp_word1, item.resp_word2, item.resp_word3);
              end
              emit_cmd = 1'b1;
              target = step_t'(step + 5'd1);
            end
          end
          default: begin
          end
        endcase
      end
    endcase
    if (emit_cmd) begin
      step_next = target;
      status_next = STAT_BUSY;
    end
    if (emit_fin) begin
      step_next = ST_END;
      status_next = fin_code;
    end
  end

  always_comb begin
    cmd = cmd_entry(4'(target));
    res_valid = emit_cmd || emit_fin;
    res.issue_command = emit_cmd;
    res.command_index = emit_cmd ? cmd.index : 6'd0;
    res.command_argument = !emit_cmd ? 32'd0 : (cmd.use_rca ? {rca_next, 16'd0} : cmd.arg);
    res.response_kind = emit_cmd ? cmd.resp : RESP_NONE;
    res.expect_data_read = emit_cmd && cmd.data;
    res.init_status = status_next;
    res.card_address = rca_next;
    res.csd_structure = csd_next;
    res.capacity_kib = cap_next;
    res.speed_class = speed_next;
    res.uhs_class = uhs_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
      ticks <= 16'd0;
      rca <= 16'd0;
      csd <= 2'd0;
      cap <= 32'd0;
      speed <= 8'd0;
      uhs <= 4'd0;
      status <= STAT_IDLE;
    end else if (go) begin
      step <= step_next;
      ticks <= ticks_next;
      rca <= rca_next;
      csd <= csd_next;
      cap <= cap_next;
      speed <= speed_next;
      uhs <= uhs_next;
      status <= status_next;
    end
  end

endmodule

// ===== hw/rtl/sd_card_init_sequencer.sv =====
// SD card bring-up sequencer: start the sequence with a start transaction, then feed
// back every command completion, data phase completion and time tick. A transaction is
// taken at the first clock edge at which it is presented, unless the input register is
// full and the output register holds a stalled result, so one transaction can be
// accepted every cycle. Its result is held on the outputs in an output register while it
// waits, and meanwhile one more transaction can enter the input register. Only the output
// register stalls the flow. Transactions that fit no step, ticks and a successful ACMD13
// completion give no result. The ACMD41 poll timeout is written through cfg_write and
// cfg_data; the user must write it only while the block is idle, which is not enforced.
// Depends on sdi_pkg and sdi_core.
module sd_card_init_sequencer
  import sdi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic        resp_ok,
  input  logic        resp_timed_out,
  input  logic [31:0] resp_word1,
  input  logic [31:0] resp_word2,
  input  logic [31:0] resp_word3,
  input  logic [31:0] resp_word4,
  input  logic        data_ok,
  input  logic [7:0]  status_byte_eight,
  input  logic [7:0]  status_byte_fourteen,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        issue_command,
  output logic [5:0]  command_index,
  output logic [31:0] command_argument,
  output logic [1:0]  response_kind,
  output logic        expect_data_read,
  output logic [2:0]  init_status,
  output logic [15:0] card_address,
  output logic [1:0]  csd_structure,
  output logic [31:0] capacity_kib,
  output logic [7:0]  speed_class,
  output logic [3:0]  uhs_class
);

  logic        held_valid;
  item_t       held;
  logic        advance;
  logic        res_valid;
  result_t     res;
  result_t     out_reg;
  logic [15:0] timeout_ticks;
  logic        word4_unused;

  assign word4_unused = ^resp_word4;
  assign advance = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && out_valid && out_stall;

  sdi_core u_core (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .go            (advance),
    .item          (held),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid <= 1'b0;
      timeout_ticks <= TIMEOUT_RESET;
    end else begin
      if (cfg_write) begin
        timeout_ticks <= cfg_data;
      end
      if (!in_stall) begin
        held_valid <= in_valid;
      end
      if (advance && res_valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held.action <= action;
      held.resp_ok <= resp_ok;
      held.resp_timed_out <= resp_timed_out;
      held.resp_word1 <= resp_word1;
      held.resp_word2 <= resp_word2;
      held.resp_word3 <= resp_word3 ^ {31'd0, word4_unused & 1'b0};
      held.data_ok <= data_ok;
      held.status_byte_eight <= status_byte_eight;
      held.status_byte_fourteen <= status_byte_fourteen;
    end
    if (advance && res_valid) begin
      out_reg <= res;
    end
  end

  assign issue_command = out_reg.issue_command;
  assign command_index = out_reg.command_index;
  assign command_argument = out_reg.command_argument;
  assign response_kind = out_reg.response_kind;
  assign expect_data_read = out_reg.expect_data_read;
  assign init_status = out_reg.init_status;
  assign card_address = out_reg.card_address;
  assign csd_structure = out_reg.csd_structure;
  assign capacity_kib = out_reg.capacity_kib;
  assign speed_class = out_reg.speed_class;
  assign uhs_class = out_reg.uhs_class;

endmodule
